// ===== src/rals_pkg.sv =====
// ----------------------------------------------------------------------------
// rals_pkg
// Shared types and constants for the RGB auto level stretch block.
// ----------------------------------------------------------------------------
package rals_pkg;

  // Pixel geometry
  localparam int PIX_W    = 8;
  localparam int CHANNELS = 3;
  localparam int DATA_W   = PIX_W * CHANNELS;
  localparam int USER_W   = 2;

  // Full-scale level and divider length (one quotient bit per step)
  localparam logic [PIX_W-1:0] LEVEL_FULL = 8'd255;
  localparam logic [PIX_W-1:0] LEVEL_ZERO = 8'd0;
  localparam int DIV_STEPS = PIX_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  // Pass select carried in tuser bit 0
  localparam logic FUNC_GATHER = 1'b0;
  localparam logic FUNC_EMIT   = 1'b1;

  // Control from the sequencer to every channel lane
  typedef struct packed {
    logic gather;  // fold the pixel into min/max
    logic clear;   // reset statistics before folding
    logic load;    // latch operands for a new stretch
    logic step;    // one divider iteration
  } rals_ctl_t;

endpackage

// ===== src/rals_lane.sv =====
// ----------------------------------------------------------------------------
// rals_lane
// One color channel: running min/max statistics and a bit-serial
// restoring divider computing floor(255 * (v - low) / (high - low)).
// ----------------------------------------------------------------------------
module rals_lane
  import rals_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  rals_ctl_t        ctl,
  input  logic [PIX_W-1:0] pix,
  output logic [PIX_W-1:0] level
);

  logic [PIX_W-1:0]   low, high;
  logic [PIX_W-1:0]   rem, numer_lo, divisor, quot;
  logic               fixed;
  logic [PIX_W-1:0]   fixed_val;

  logic [PIX_W-1:0]   base_low, base_high;
  logic [PIX_W-1:0]   span, off;
  logic [2*PIX_W-1:0] numer;
  logic [PIX_W:0]     trial;
  logic               fits;

  // Statistics base (cleared at frame start), operands and divider trial
  always_comb begin
    base_low  = ctl.clear ? LEVEL_FULL : low;
    base_high = ctl.clear ? LEVEL_ZERO : high;
    span      = high - low;
    off       = pix - low;
    // 255 * off = 256 * off - off
    numer     = {off, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, off};
    trial     = {rem, numer_lo[PIX_W-1]};
    fits      = (trial >= {1'b0, divisor});
  end

  // Running min/max
  always_ff @(posedge clk) begin
    if (rst) begin
      low  <= LEVEL_FULL;
      high <= LEVEL_ZERO;
    end else if (ctl.gather) begin
      low  <= (pix < base_low)  ? pix : base_low;
      high <= (pix > base_high) ? pix : base_high;
    end
  end

  // Divider: special cases resolved at load, else shift-subtract per step
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem      <= numer[2*PIX_W-1:PIX_W];
      numer_lo <= numer[PIX_W-1:0];
      divisor  <= span;
      quot     <= LEVEL_ZERO;
      if (high <= low || pix <= low) begin
        fixed     <= 1'b1;
        fixed_val <= LEVEL_ZERO;
      end else if (off >= span) begin
        fixed     <= 1'b1;
        fixed_val <= LEVEL_FULL;
      end else begin
        fixed     <= 1'b0;
        fixed_val <= LEVEL_ZERO;
      end
    end else if (ctl.step) begin
      rem      <= fits ? PIX_W'(trial - {1'b0, divisor}) : trial[PIX_W-1:0];
      numer_lo <= {numer_lo[PIX_W-2:0], 1'b0};
      quot     <= {quot[PIX_W-2:0], fits};
    end
  end

  assign level = fixed ? fixed_val : quot;

endmodule

// ===== src/rgb_auto_level_stretch.sv =====
// ----------------------------------------------------------------------------
// rgb_auto_level_stretch
// Per-channel automatic level stretch of 8-bit RGB pixels, two passes.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: tdata = {blue, green, red}, tuser = {start_frame, func}.
//   func = 0 (gather): the item widens the per-channel min/max; start_frame
//   clears the statistics first. No output item.
//   func = 1 (emit): the item is stretched per channel to
//   floor(255*(v-min)/(max-min)), saturated; a flat or empty channel gives 0.
//   Output stream m_axis: tdata = {blue, green, red}.
//   An emit item loads its operands at the accepting edge; the 8-step
//   bit-serial divider in each of the three channel lanes then runs, and
//   the result moves to the output register, raising m_axis_tvalid.
//   Throughput: one gather item per cycle while no emit item is in flight;
//   an emit item holds off further input, which reopens the cycle after
//   its result moves to the output register.
//   Reset: statistics go to min = 255, max = 0; no item is pending.
//   Stall: a finished result waits in the output register; the block keeps
//   taking gather items meanwhile, while an emit item waits until the
//   output register frees before its result is handed over.
// ----------------------------------------------------------------------------
module rgb_auto_level_stretch
  import rals_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // red_in, green_in, blue_in
  input  logic [USER_W-1:0] s_axis_tuser,   // func, start_frame
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata    // red_out, green_out, blue_out
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_HOLD} state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  logic             accept;
  logic             out_free;
  rals_ctl_t        ctl;
  logic [PIX_W-1:0] level [CHANNELS];
  logic [DATA_W-1:0] merged;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Lane control
  always_comb begin
    ctl.gather = accept && (s_axis_tuser[0] == FUNC_GATHER);
    ctl.clear  = s_axis_tuser[1];
    ctl.load   = accept && (s_axis_tuser[0] == FUNC_EMIT);
    ctl.step   = (state == ST_DIVIDE);
  end

  // Channel lanes
  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    rals_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .pix   (s_axis_tdata[PIX_W*i +: PIX_W]),
      .level (level[i])
    );
  end

  // Merge lane results into one output word
  always_comb begin
    merged = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      merged[PIX_W*i +: PIX_W] = level[i];
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Output valid: set on hand-over, cleared once taken
      if (state == ST_HOLD && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (ctl.load) begin
            state <= ST_DIVIDE;
            cnt   <= '0;
          end
        end
        ST_DIVIDE: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            m_axis_tdata <= merged;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Assertions
  a_emit_starts_divide: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == FUNC_EMIT)
      |=> state == ST_DIVIDE)
    else $error("emit item did not start the divider");

  a_gather_no_result: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == FUNC_GATHER && !m_axis_tvalid)
      |=> !m_axis_tvalid)
    else $error("gather item produced an output item");

  a_divide_exits_to_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE && cnt == CNT_LAST) |=> state == ST_HOLD)
    else $error("divider did not finish after its last step");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE || state == ST_HOLD) |-> !s_axis_tready)
    else $error("input taken while a stretch is in flight");

endmodule

// ===== tb/sv/rgb_auto_level_stretch_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_auto_level_stretch_check
// Watches both streams of the level stretch block. It keeps its own per-channel
// min/max from gather items, works out the stretched pixel for each emit item
// and compares every output item field by field, in order.
// ----------------------------------------------------------------------------
module rgb_auto_level_stretch_check
  import rals_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // red_in, green_in, blue_in
  input  logic [USER_W-1:0] s_axis_tuser,   // func, start_frame
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [DATA_W-1:0] m_axis_tdata,   // red_out, green_out, blue_out
  output int                pending,
  output int                fail_count
);

  typedef logic [PIX_W-1:0] level_t;

  // Gathered statistics, one entry per channel (red, green, blue)
  level_t gathered_low  [CHANNELS];
  level_t gathered_high [CHANNELS];

  // Stretched pixels still owed by the block, oldest first
  logic [DATA_W-1:0] stretched_q [$];

  string chan_name [CHANNELS] = '{"red", "green", "blue"};

  // floor(255 * (v - lo) / (hi - lo)), saturated; empty or flat channel gives 0
  function automatic level_t stretch_level(level_t v, level_t lo, level_t hi);
    int unsigned span_w;
    int unsigned offs;
    if (hi <= lo) return LEVEL_ZERO;
    if (v <= lo) return LEVEL_ZERO;
    span_w = int'(hi) - int'(lo);
    offs   = int'(v) - int'(lo);
    if (offs >= span_w) return LEVEL_FULL;
    return level_t'((int'(LEVEL_FULL) * offs) / span_w);
  endfunction

  // Predict on input items, compare on output items
  always @(posedge clk) begin : watch
    logic [DATA_W-1:0] want;
    level_t            v;
    level_t            got;
    level_t            exp_v;
    int                c;
    if (rst) begin
      for (c = 0; c < CHANNELS; c++) begin
        gathered_low[c]  = LEVEL_FULL;
        gathered_high[c] = LEVEL_ZERO;
      end
      stretched_q.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == FUNC_GATHER) begin
          for (c = 0; c < CHANNELS; c++) begin
            v = s_axis_tdata[c*PIX_W +: PIX_W];
            // start flag clears, then the pixel still counts
            if (s_axis_tuser[1]) begin
              gathered_low[c]  = LEVEL_FULL;
              gathered_high[c] = LEVEL_ZERO;
            end
            if (v < gathered_low[c]) gathered_low[c] = v;
            if (v > gathered_high[c]) gathered_high[c] = v;
          end
        end else begin
          for (c = 0; c < CHANNELS; c++) begin
            v = s_axis_tdata[c*PIX_W +: PIX_W];
            want[c*PIX_W +: PIX_W] = stretch_level(v, gathered_low[c], gathered_high[c]);
          end
          stretched_q.push_back(want);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (stretched_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected output item, expected none, actual %h",
                   $time, m_axis_tdata);
        end else begin
          want = stretched_q.pop_front();
          for (c = 0; c < CHANNELS; c++) begin
            exp_v = want[c*PIX_W +: PIX_W];
            got   = m_axis_tdata[c*PIX_W +: PIX_W];
            if (got !== exp_v) begin
              fail_count++;
              $display("%0t: %s_out mismatch, expected %0d, actual %0d",
                       $time, chan_name[c], exp_v, got);
            end
          end
        end
      end
      pending <= stretched_q.size();
    end
  end

endmodule

// ===== tb/sv/rgb_auto_level_stretch_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_auto_level_stretch_test
// Drives gather and emit pixels into the level stretch block: a directed
// opening over the corner cases, then random frames under several idle and
// stall patterns, one long output hold-off and drains between phases.
// ----------------------------------------------------------------------------
module rgb_auto_level_stretch_test
  import rals_pkg::*;
();

  typedef logic [PIX_W-1:0] level_t;

  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_ITEMS   = 450;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;  // red_in, green_in, blue_in
  logic [USER_W-1:0] s_axis_tuser  = '0;  // func, start_frame
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;        // red_out, green_out, blue_out

  int   pending;
  int   fail_count;
  int   src_idle_pct   = 0;
  int   sink_stall_pct = 0;
  int   hold_left      = 0;
  logic hold_toggle    = 1'b0;
  logic hold_seen      = 1'b0;
  int   quiet_cycles   = 0;
  int   items_sent     = 0;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  rgb_auto_level_stretch u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rgb_auto_level_stretch_check u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending       (pending),
    .fail_count    (fail_count)
  );

  // Output side: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_toggle != hold_seen) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES - 1;
      hold_seen     <= hold_toggle;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog: cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("rgb_auto_level_stretch_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one pixel, with random idle cycles ahead of it
  task automatic send_pixel(input logic func, input logic start,
                            input level_t r, input level_t g, input level_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    s_axis_tuser  <= {start, func};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // Stop offering until every stretched pixel has come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Random level in lo..hi, clipped to the pixel range
  function automatic level_t pick_near(int lo, int hi);
    if (lo < 0) lo = 0;
    if (hi > 255) hi = 255;
    return level_t'($urandom_range(lo, hi));
  endfunction

  // One frame: gather pixels inside a per-channel window, then emit pixels
  task automatic send_frame();
    int     base [CHANNELS];
    int     span [CHANNELS];
    level_t px [CHANNELS];
    int     n_gather;
    int     n_emit;
    int     c;
    int     k;
    for (c = 0; c < CHANNELS; c++) begin
      case ($urandom_range(3))
        0: span[c] = 0;
        1: span[c] = $urandom_range(1, 8);
        2: span[c] = $urandom_range(9, 120);
        default: span[c] = $urandom_range(121, 255);
      endcase
      base[c] = $urandom_range(0, 255 - span[c]);
    end
    n_gather = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
    n_emit   = $urandom_range(1, 12);
    for (k = 0; k < n_gather; k++) begin
      for (c = 0; c < CHANNELS; c++) begin
        if (k == 0) px[c] = level_t'(base[c]);
        else if (k == 1) px[c] = level_t'(base[c] + span[c]);
        else px[c] = level_t'(base[c] + $urandom_range(0, span[c]));
      end
      // mostly a fresh frame; sometimes keep the earlier statistics
      send_pixel(FUNC_GATHER, (k == 0) && ($urandom_range(9) != 0), px[0], px[1], px[2]);
    end
    for (k = 0; k < n_emit; k++) begin
      for (c = 0; c < CHANNELS; c++) begin
        if ($urandom_range(3) == 0) px[c] = level_t'($urandom_range(255));
        else px[c] = pick_near(base[c] - 3, base[c] + span[c] + 3);
      end
      send_pixel(FUNC_EMIT, 1'($urandom_range(1)), px[0], px[1], px[2]);
    end
  endtask

  // Mostly well-formed frames, some fully random items
  task automatic run_random(input int n_items);
    int stop_at;
    int n_noise;
    int k;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 85) begin
        send_frame();
      end else begin
        n_noise = $urandom_range(1, 6);
        for (k = 0; k < n_noise; k++)
          send_pixel(1'($urandom_range(1)), 1'($urandom_range(1)),
                     level_t'($urandom_range(255)), level_t'($urandom_range(255)),
                     level_t'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: nothing gathered yet, start flag on an emit is ignored
    send_pixel(FUNC_EMIT,   1'b1, 8'd0,   8'd255, 8'd128);
    send_pixel(FUNC_EMIT,   1'b0, 8'd255, 8'd0,   8'd1);
    // Single pixel frame: every channel flat
    send_pixel(FUNC_GATHER, 1'b1, 8'd10,  8'd0,   8'd255);
    send_pixel(FUNC_EMIT,   1'b0, 8'd10,  8'd0,   8'd255);
    // Widen: red 10..20, green and blue 0..255
    send_pixel(FUNC_GATHER, 1'b0, 8'd20,  8'd255, 8'd0);
    send_pixel(FUNC_EMIT,   1'b0, 8'd5,   8'd0,   8'd255);
    send_pixel(FUNC_EMIT,   1'b0, 8'd25,  8'd128, 8'd1);
    send_pixel(FUNC_EMIT,   1'b0, 8'd15,  8'd255, 8'd254);
    send_pixel(FUNC_EMIT,   1'b1, 8'd20,  8'd127, 8'd0);
    // Restart: the start pixel counts as the first of the new frame
    send_pixel(FUNC_GATHER, 1'b1, 8'd100, 8'd100, 8'd100);
    send_pixel(FUNC_GATHER, 1'b0, 8'd101, 8'd200, 8'd100);
    send_pixel(FUNC_EMIT,   1'b0, 8'd100, 8'd101, 8'd100);
    send_pixel(FUNC_EMIT,   1'b0, 8'd101, 8'd150, 8'd255);
    send_pixel(FUNC_EMIT,   1'b0, 8'd99,  8'd199, 8'd0);
    // Start flag on a later gather pixel
    send_pixel(FUNC_GATHER, 1'b1, 8'd0,   8'd0,   8'd0);
    send_pixel(FUNC_GATHER, 1'b1, 8'd255, 8'd255, 8'd255);
    send_pixel(FUNC_EMIT,   1'b0, 8'd0,   8'd255, 8'd128);
    send_pixel(FUNC_GATHER, 1'b0, 8'd0,   8'd1,   8'd254);
    send_pixel(FUNC_EMIT,   1'b0, 8'd1,   8'd254, 8'd253);
    send_pixel(FUNC_EMIT,   1'b0, 8'd255, 8'd0,   8'd254);
    drain_results();

    // No idling
    run_random(PHASE_ITEMS);
    drain_results();

    // Sender idle most of the time
    src_idle_pct = 70;
    run_random(PHASE_ITEMS);
    drain_results();

    // Receiver stalling most of the time
    src_idle_pct = 0;
    sink_stall_pct <= 70;
    run_random(PHASE_ITEMS);
    drain_results();

    // Both sides idling
    src_idle_pct = 33;
    sink_stall_pct <= 33;
    run_random(PHASE_ITEMS);
    drain_results();

    // Long output hold-off while items keep coming, so the input stalls
    src_idle_pct = 0;
    sink_stall_pct <= 0;
    hold_toggle <= ~hold_toggle;
    run_random(80);
    drain_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("rgb_auto_level_stretch_test OK");
    end else begin
      $display("rgb_auto_level_stretch_test NOT OK");
    end
    $finish;
  end

endmodule
